// File: hdl/ftlp_pkg.sv
// Flow table package: opcodes, status codes, and the request/result types
// shared by the front (hash) and back (probe) sections. No dependencies.
`timescale 1ns / 1ps
package ftlp_pkg;
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_NOSLOT = 2'd2;
   localparam logic [1:0] ST_ZERO   = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [11:0] vlan_id;
   } key_type;

   // classification done in the front section
   typedef struct packed {
      logic        skip;      // answer without probing
      logic [1:0]  status;    // status when skipped
   } cls_type;
endpackage

// File: hdl/flow_table_linear_probe_core.sv
// Flow table with linear probing. Hashing is a multiply plus a 46-step
// modulo by rows_in_use; a request that needs no probe is answered once its
// hash is done, and a probe takes a read and a compare for each slot it visits.
// The front hashes the next request while the back probes; new requests wait
// until the front is idle and the queue entry has moved to the back section.
// After reset a clearing pass over all TABLE_DEPTH slots empties the handle store
// with busy high; results show for one cycle on rsp_valid and cannot be stalled.
`timescale 1ns / 1ps
module flow_table_linear_probe_core #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [11:0] req_vlan_id,
   input  logic [31:0] req_handle_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_hit,
   output logic [31:0] rsp_handle_out,
   output logic [9:0]  rsp_slot,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);
   localparam int AW = $clog2(TABLE_DEPTH);

   logic [10:0]             rows_ff;
   logic [AW:0]             rows_use;
   logic                    clearing, fbusy;
   logic                    q_valid, q_pop;
   ftlp_pkg::key_type       key, q_key;
   logic [HANDLE_WIDTH-1:0] q_handle;
   ftlp_pkg::cls_type       q_cls;
   logic [AW-1:0]           q_home;

   always_ff @(posedge clock) begin
      if (reset) rows_ff <= 11'd1024;
      else if (csr_we) rows_ff <= csr_wdata;
   end

   // zero rows act as one, more than the table acts as the table
   always_comb begin
      rows_use = (AW+1)'(rows_ff);
      if (rows_ff == 11'd0) rows_use = (AW+1)'(1);
      if (rows_ff > 11'(TABLE_DEPTH)) rows_use = (AW+1)'(TABLE_DEPTH);
   end

   assign key  = '{op: req_op, src_ip: req_src_ip, dst_ip: req_dst_ip,
                   src_port: req_src_port, dst_port: req_dst_port, vlan_id: req_vlan_id};
   // hold new requests until the queue entry has moved to the back section
   assign busy = fbusy || clearing || q_valid;

   ftlp_front #(.TABLE_DEPTH(TABLE_DEPTH), .HANDLE_WIDTH(HANDLE_WIDTH)) u_front (
      .clock(clock), .reset(reset), .start(start && !busy), .busy(fbusy),
      .key_i(key), .handle_i(HANDLE_WIDTH'(req_handle_in)),
      .rows_i(rows_use),
      .q_valid(q_valid), .q_pop(q_pop), .q_key(q_key),
      .q_handle(q_handle), .q_cls(q_cls), .q_home(q_home));

   ftlp_back #(.TABLE_DEPTH(TABLE_DEPTH), .HANDLE_WIDTH(HANDLE_WIDTH)) u_back (
      .clock(clock), .reset(reset), .rows_i(rows_use),
      .q_valid(q_valid), .q_pop(q_pop), .q_key(q_key), .q_handle(q_handle),
      .q_cls(q_cls), .q_home(q_home), .clearing_o(clearing),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_hit(rsp_hit),
      .rsp_handle_out(rsp_handle_out), .rsp_slot(rsp_slot));
endmodule

// File: hdl/ftlp_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ftlp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// File: hdl/ftlp_front.sv
// Front section: accepts requests, computes the home slot step by step
// (multiply, then shift-subtract modulo), and classifies the op.
// Depends on ftlp_pkg.
`timescale 1ns / 1ps
module ftlp_front #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  ftlp_pkg::key_type               key_i,
   input  logic [HANDLE_WIDTH-1:0]         handle_i,
   input  logic [$clog2(TABLE_DEPTH):0]    rows_i,
   // queue entry toward back section
   output logic                            q_valid,
   input  logic                            q_pop,
   output ftlp_pkg::key_type               q_key,
   output logic [HANDLE_WIDTH-1:0]         q_handle,
   output ftlp_pkg::cls_type               q_cls,
   output logic [$clog2(TABLE_DEPTH)-1:0]  q_home
);
   localparam int RW = $clog2(TABLE_DEPTH) + 1;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PW = 46;                 // 33-bit xor times 13-bit factor
   localparam int CW = $clog2(PW + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_MOD  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]              state_ff, state_in;
   ftlp_pkg::key_type       key_ff;
   logic [HANDLE_WIDTH-1:0] handle_ff;
   logic [RW-1:0]           rows_ff;
   logic [32:0]             mix_ff;
   logic [PW-1:0]           rem_ff, rem_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   ftlp_pkg::cls_type       cls_ff, cls_c;
   logic                    qv_ff, qv_in;
   logic [AW-1:0]           home_ff;
   logic [PW+RW-1:0]        trial;
   logic [32:0]             mix_c;
   logic [RW-1:0]           rows_c;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      rows_c = rows_i;
      if (rows_i == '0) rows_c = RW'(1);
      if (rows_i > RW'(TABLE_DEPTH)) rows_c = RW'(TABLE_DEPTH);
      mix_c = {1'b0, key_i.src_ip + key_i.dst_ip}
              ^ {16'd0, {1'b0, key_i.src_port} + {1'b0, key_i.dst_port}};
   end

   // table-full check is left to the back section, which owns the entry count
   always_comb begin
      cls_c.skip   = 1'b0;
      cls_c.status = ftlp_pkg::ST_OK;
      if (key_i.op == ftlp_pkg::OP_NONE) begin
         cls_c.skip = 1'b1;
      end else if (key_i.op == ftlp_pkg::OP_INSERT && handle_i == '0) begin
         cls_c.skip   = 1'b1;
         cls_c.status = ftlp_pkg::ST_ZERO;
      end
   end

   // restoring shift-subtract: one quotient bit per cycle
   assign trial = {{RW{1'b0}}, rem_ff} - ({{PW{1'b0}}, rows_ff} << (cnt_ff - CW'(1)));

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      qv_in    = qv_ff;
      if (q_pop) qv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_MUL;
         S_MUL: begin
            rem_in   = PW'(mix_ff) * PW'({1'b0, key_ff.vlan_id} + 13'd1);
            cnt_in   = CW'(PW);
            state_in = S_MOD;
         end
         S_MOD: begin
            if (!trial[PW+RW-1]) rem_in = trial[PW-1:0];
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) state_in = S_DONE;
         end
         S_DONE: if (!qv_ff || q_pop) begin
            qv_in    = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         qv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         qv_ff    <= qv_in;
      end
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (state_ff == S_IDLE && start) begin
         key_ff    <= key_i;
         handle_ff <= handle_i;
         rows_ff   <= rows_c;
         mix_ff    <= mix_c;
         cls_ff    <= cls_c;
      end
      if (state_ff == S_DONE && (!qv_ff || q_pop)) home_ff <= AW'(rem_ff);
   end

   assign q_valid  = qv_ff;
   assign q_key    = key_ff;
   assign q_handle = handle_ff;
   assign q_cls    = cls_ff;
   assign q_home   = home_ff;
endmodule

// File: hdl/ftlp_back.sv
// Back section: probes the table from the home slot, one slot at a time
// (read then compare), and performs insert/lookup/delete.
// Depends on ftlp_pkg and ftlp_ram.
`timescale 1ns / 1ps
module ftlp_back #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(TABLE_DEPTH):0]   rows_i,
   input  logic                           q_valid,
   output logic                           q_pop,
   input  ftlp_pkg::key_type              q_key,
   input  logic [HANDLE_WIDTH-1:0]        q_handle,
   input  ftlp_pkg::cls_type              q_cls,
   input  logic [$clog2(TABLE_DEPTH)-1:0] q_home,
   output logic                           clearing_o,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_hit,
   output logic [31:0]                    rsp_handle_out,
   output logic [9:0]                     rsp_slot
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int RW = AW + 1;
   localparam int KW = 108;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;

   logic [2:0]              state_ff, state_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [RW-1:0]           left_ff, left_in;
   logic [RW-1:0]           rows_ff;
   logic [10:0]             count_ff, count_in;
   ftlp_pkg::key_type       key_ff;
   logic [HANDLE_WIDTH-1:0] handle_ff;
   logic                    rv_ff, rv_in;
   logic [1:0]              rst_ff, rst_in;
   logic                    rhit_ff, rhit_in;
   logic [31:0]             rho_ff, rho_in;
   logic [AW-1:0]           rslot_ff, rslot_in;

   logic                    k_we, h_we;
   logic [KW-1:0]           k_wd, k_rd;
   logic [HANDLE_WIDTH-1:0] h_wd, h_rd;
   logic                    match, empty;
   logic [AW-1:0]           idx_nx;

   ftlp_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_key (
      .clock(clock), .we(k_we), .addr(idx_ff), .wdata(k_wd), .rdata(k_rd));
   ftlp_ram #(.WIDTH(HANDLE_WIDTH), .DEPTH(TABLE_DEPTH)) u_handle (
      .clock(clock), .we(h_we), .addr(idx_ff), .wdata(h_wd), .rdata(h_rd));

   assign k_wd = {key_ff.src_ip, key_ff.dst_ip, key_ff.src_port, key_ff.dst_port,
                  key_ff.vlan_id};
   assign empty = (h_rd == '0);
   always_comb begin
      logic fwd, rev;
      fwd = k_rd[107:76] == key_ff.src_ip && k_rd[75:44] == key_ff.dst_ip &&
            k_rd[43:28] == key_ff.src_port && k_rd[27:12] == key_ff.dst_port;
      rev = k_rd[107:76] == key_ff.dst_ip && k_rd[75:44] == key_ff.src_ip &&
            k_rd[43:28] == key_ff.dst_port && k_rd[27:12] == key_ff.src_port;
      match = (fwd || rev) && k_rd[11:0] == key_ff.vlan_id;
   end
   assign idx_nx = ({1'b0, idx_ff} + RW'(1) >= rows_ff) ? '0 : idx_ff + AW'(1);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      left_in  = left_ff;
      count_in = count_ff;
      rv_in    = 1'b0;
      rst_in   = rst_ff;
      rhit_in  = 1'b0;
      rho_in   = '0;
      rslot_in = rslot_ff;
      q_pop    = 1'b0;
      k_we     = 1'b0;
      h_we     = 1'b0;
      h_wd     = '0;
      unique case (state_ff)
         S_CLEAR: begin
            h_we   = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == AW'(TABLE_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (q_valid) begin
            q_pop = 1'b1;
            // keep home slot for the skip, full and no-slot answers
            rslot_in = q_home;
            if (q_cls.skip) begin
               rv_in  = 1'b1;
               rst_in = q_cls.status;
            end else if (q_key.op == ftlp_pkg::OP_INSERT &&
                         {count_ff, 3'b000} > 14'(rows_i)) begin
               rv_in  = 1'b1;
               rst_in = ftlp_pkg::ST_FULL;
            end else begin
               idx_in   = q_home;
               left_in  = rows_i;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_CMP;
         S_CMP: begin
            if (empty || match) begin
               rv_in    = 1'b1;
               rst_in   = ftlp_pkg::ST_OK;
               rslot_in = idx_ff;
               state_in = S_IDLE;
               if (key_ff.op == ftlp_pkg::OP_INSERT) begin
                  k_we = 1'b1;
                  h_we = 1'b1;
                  h_wd = handle_ff;
                  if (empty) count_in = count_ff + 11'd1;
               end else if (!empty) begin
                  rhit_in = 1'b1;
                  if (key_ff.op == ftlp_pkg::OP_LOOKUP) begin
                     rho_in = 32'(h_rd);
                  end else begin
                     h_we     = 1'b1;
                     count_in = count_ff - 11'd1;
                  end
               end
            end else if (left_ff == RW'(1)) begin
               rv_in    = 1'b1;
               rst_in   = ftlp_pkg::ST_NOSLOT;
               state_in = S_IDLE;
            end else begin
               left_in  = left_ff - RW'(1);
               idx_in   = idx_nx;
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      left_ff  <= left_in;
      rst_ff   <= rst_in;
      rhit_ff  <= rhit_in;
      rho_ff   <= rho_in;
      rslot_ff <= rslot_in;
      if (state_ff == S_IDLE && q_valid) begin
         key_ff    <= q_key;
         handle_ff <= q_handle;
         rows_ff   <= rows_i;
      end
   end

   assign clearing_o     = (state_ff == S_CLEAR);
   assign rsp_valid      = rv_ff;
   assign rsp_status     = rst_ff;
   assign rsp_hit        = rhit_ff;
   assign rsp_handle_out = rho_ff;
   assign rsp_slot       = 10'(rslot_ff);
endmodule

// File: test/tb_top.sv
// Self-checking testbench for flow_table_linear_probe_core: directed table, then random
// phases over several rows_in_use settings. Depends on ftlp_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
   import ftlp_pkg::*;

   localparam int DEPTH = 1024;
   localparam int SETTLE = 80;

   typedef struct {
      logic [1:0]  status;
      logic        hit;
      logic [31:0] handle;
      logic [9:0]  slot;
   } flow_result_t;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] sip;
      logic [31:0] dip;
      logic [15:0] sp;
      logic [15:0] dp;
      logic [11:0] vl;
      logic [31:0] hin;
      bit          typed;
      flow_result_t res;
   } flow_row_t;

   typedef struct {
      logic [31:0] sip;
      logic [31:0] dip;
      logic [15:0] sp;
      logic [15:0] dp;
      logic [11:0] vl;
   } flow_key_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = OP_LOOKUP;
   logic [31:0] req_src_ip = '0;
   logic [31:0] req_dst_ip = '0;
   logic [15:0] req_src_port = '0;
   logic [15:0] req_dst_port = '0;
   logic [11:0] req_vlan_id = '0;
   logic [31:0] req_handle_in = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_hit;
   logic [31:0] rsp_handle_out;
   logic [9:0]  rsp_slot;
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;

   // predictor copy of the table
   logic [63:0] addr_keys [DEPTH];
   logic [43:0] port_keys [DEPTH];
   logic [31:0] handles [DEPTH];
   logic [10:0] entry_count;
   logic [10:0] rows_reg;

   flow_result_t pending_results[$];
   flow_row_t    directed_rows[$];
   flow_key_t    key_pool[$];
   int           mismatches = 0;
   bit           idle_gaps = 1'b1;

   flow_table_linear_probe_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_src_ip(req_src_ip), .req_dst_ip(req_dst_ip),
      .req_src_port(req_src_port), .req_dst_port(req_dst_port),
      .req_vlan_id(req_vlan_id), .req_handle_in(req_handle_in),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_hit(rsp_hit),
      .rsp_handle_out(rsp_handle_out), .rsp_slot(rsp_slot),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200_000_000;
      $display("flow_table_linear_probe_core test failed");
      $finish;
   end

   function automatic bit key_match(int s, flow_row_t r);
      logic [31:0] ks, kd;
      logic [15:0] ksp, kdp;
      logic [11:0] kv;
      bit fwd, rev;
      ks = addr_keys[s][63:32];
      kd = addr_keys[s][31:0];
      ksp = port_keys[s][43:28];
      kdp = port_keys[s][27:12];
      kv = port_keys[s][11:0];
      fwd = ks == r.sip && kd == r.dip && ksp == r.sp && kdp == r.dp;
      rev = ks == r.dip && kd == r.sip && ksp == r.dp && kdp == r.sp;
      return (fwd || rev) && kv == r.vl;
   endfunction

   // advance the table copy by one request and return its result
   function automatic flow_result_t probe_table(flow_row_t r);
      flow_result_t res;
      int rows, idx, slot;
      logic [31:0] sum_ip;
      logic [16:0] sum_port;
      logic [63:0] h;
      bit found;
      rows = (rows_reg == 0) ? 1 : (rows_reg > DEPTH) ? DEPTH : rows_reg;
      sum_ip = r.sip + r.dip;
      sum_port = {1'b0, r.sp} + {1'b0, r.dp};
      h = {32'b0, sum_ip ^ {15'b0, sum_port}} * {51'b0, {1'b0, r.vl} + 13'd1};
      slot = int'(h % rows);
      res.status = ST_OK;
      res.hit = 1'b0;
      res.handle = '0;
      found = 1'b0;
      if (r.op == OP_NONE) begin
         res.slot = slot[9:0];
         return res;
      end
      if (r.op == OP_INSERT) begin
         if (r.hin == 0) begin
            res.status = ST_ZERO;
            res.slot = slot[9:0];
            return res;
         end
         if (int'(entry_count) * 8 > rows) begin
            res.status = ST_FULL;
            res.slot = slot[9:0];
            return res;
         end
      end
      idx = slot;
      for (int n = 0; n < rows; n++) begin
         if (handles[idx] == 0 || key_match(idx, r)) begin
            found = 1'b1;
            slot = idx;
            break;
         end
         idx = (idx + 1 >= rows) ? 0 : idx + 1;
      end
      res.slot = slot[9:0];
      if (!found) begin
         res.status = ST_NOSLOT;
      end else if (r.op == OP_INSERT) begin
         if (handles[slot] == 0) entry_count = entry_count + 11'd1;
         addr_keys[slot] = {r.sip, r.dip};
         port_keys[slot] = {r.sp, r.dp, r.vl};
         handles[slot] = r.hin;
      end else if (handles[slot] != 0) begin
         res.hit = 1'b1;
         if (r.op == OP_LOOKUP) begin
            res.handle = handles[slot];
         end else begin
            handles[slot] = '0;
            entry_count = entry_count - 11'd1;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      flow_result_t want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: status %0d slot %0d",
                                           rsp_status, rsp_slot);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status || rsp_hit !== want.hit ||
                rsp_handle_out !== want.handle || rsp_slot !== want.slot) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d hit %0d h %h slot %0d, got st %0d hit %0d h %h slot %0d",
                           want.status, want.hit, want.handle, want.slot,
                           rsp_status, rsp_hit, rsp_handle_out, rsp_slot);
            end
         end
      end
   end

   task automatic add_row(logic [1:0] op, flow_key_t k, logic [31:0] hin, bit typed,
                          logic [1:0] st, logic hit, logic [31:0] hout, logic [9:0] slot);
      flow_row_t r;
      r.op = op; r.sip = k.sip; r.dip = k.dip; r.sp = k.sp; r.dp = k.dp; r.vl = k.vl;
      r.hin = hin; r.typed = typed;
      r.res.status = st; r.res.hit = hit; r.res.handle = hout; r.res.slot = slot;
      directed_rows.push_back(r);
   endtask

   // drive one request from the falling edge and hold it until the transfer
   task automatic send_request(flow_row_t r);
      flow_result_t res;
      if (idle_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clock);
      req_op = r.op; req_src_ip = r.sip; req_dst_ip = r.dip;
      req_src_port = r.sp; req_dst_port = r.dp; req_vlan_id = r.vl;
      req_handle_in = r.hin;
      start = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      res = probe_table(r);
      pending_results.push_back(r.typed ? r.res : res);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain_and_write(logic [10:0] rows);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = rows;
      @(negedge clock);
      csr_we = 1'b0;
      rows_reg = rows;
   endtask

   function automatic flow_key_t random_key();
      flow_key_t k;
      k.sip = $urandom; k.dip = $urandom;
      k.sp = 16'($urandom); k.dp = 16'($urandom); k.vl = 12'($urandom);
      if ($urandom_range(0, 9) == 0) k.sip = '1;
      if ($urandom_range(0, 9) == 0) k.vl = '0;
      return k;
   endfunction

   initial begin
      flow_key_t zero_key, max_key, key_a, key_a_rev, k, t;
      flow_row_t r;
      logic [10:0] phases [9] = '{11'd1, 11'd8, 11'd2047, 11'd16, 11'd0,
                                  11'd1000, 11'd64, 11'd1023, 11'd1024};
      int pick;

      for (int i = 0; i < DEPTH; i++) begin
         addr_keys[i] = '0; port_keys[i] = '0; handles[i] = '0;
      end
      entry_count = '0;
      rows_reg = 11'd1024;

      zero_key = '{32'h0, 32'h0, 16'h0, 16'h0, 12'h0};
      max_key = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 12'hFFF};
      key_a = '{32'h0A00_0001, 32'hC0A8_0101, 16'h1234, 16'h0050, 12'h005};
      key_a_rev = '{32'hC0A8_0101, 32'h0A00_0001, 16'h0050, 16'h1234, 12'h005};

      add_row(OP_LOOKUP, zero_key, 32'h0, 1, ST_OK, 1'b0, 32'h0, 10'd0);
      add_row(OP_INSERT, zero_key, 32'h0, 1, ST_ZERO, 1'b0, 32'h0, 10'd0);
      add_row(OP_INSERT, zero_key, 32'hFFFF_FFFF, 1, ST_OK, 1'b0, 32'h0, 10'd0);
      add_row(OP_LOOKUP, zero_key, 32'h0, 1, ST_OK, 1'b1, 32'hFFFF_FFFF, 10'd0);
      add_row(OP_INSERT, max_key, 32'h1, 0, ST_OK, 0, 0, 0);
      add_row(OP_LOOKUP, max_key, 32'h0, 0, ST_OK, 0, 0, 0);
      add_row(OP_INSERT, key_a, 32'h5, 0, ST_OK, 0, 0, 0);
      add_row(OP_LOOKUP, key_a_rev, 32'h0, 0, ST_OK, 0, 0, 0);
      add_row(OP_INSERT, key_a_rev, 32'h6, 0, ST_OK, 0, 0, 0);
      add_row(OP_LOOKUP, key_a, 32'h0, 0, ST_OK, 0, 0, 0);
      add_row(OP_DELETE, key_a, 32'h0, 0, ST_OK, 0, 0, 0);
      add_row(OP_DELETE, key_a_rev, 32'h0, 0, ST_OK, 0, 0, 0);
      add_row(OP_NONE, zero_key, 32'hFFFF_FFFF, 1, ST_OK, 1'b0, 32'h0, 10'd0);
      add_row(OP_DELETE, zero_key, 32'h0, 1, ST_OK, 1'b1, 32'h0, 10'd0);
      add_row(OP_LOOKUP, zero_key, 32'h0, 1, ST_OK, 1'b0, 32'h0, 10'd0);
      add_row(OP_DELETE, max_key, 32'h0, 0, ST_OK, 0, 0, 0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      foreach (phases[p]) begin
         drain_and_write(phases[p]);
         key_pool.delete();
         if (p == 8) idle_gaps = 1'b0;
         for (int n = 0; n < 205; n++) begin
            if (key_pool.size() == 0 || $urandom_range(0, 3) == 0) begin
               k = random_key();
               key_pool.push_back(k);
               if (key_pool.size() > 12) void'(key_pool.pop_front());
            end else begin
               pick = $urandom_range(0, key_pool.size() - 1);
               k = key_pool[pick];
               if ($urandom_range(0, 1)) begin
                  t = k;
                  k.sip = t.dip; k.dip = t.sip; k.sp = t.dp; k.dp = t.sp;
               end
            end
            pick = $urandom_range(0, 99);
            r.op = (pick < 40) ? OP_INSERT : (pick < 75) ? OP_LOOKUP :
                   (pick < 95) ? OP_DELETE : OP_NONE;
            r.sip = k.sip; r.dip = k.dip; r.sp = k.sp; r.dp = k.dp; r.vl = k.vl;
            r.hin = ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom;
            r.typed = 1'b0;
            send_request(r);
         end
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("flow_table_linear_probe_core test passed");
      end else begin
         $display("flow_table_linear_probe_core test failed");
      end
      $finish;
   end
endmodule

// File: sim.f
hdl/ftlp_pkg.sv
hdl/ftlp_ram.sv
hdl/ftlp_front.sv
hdl/ftlp_back.sv
hdl/flow_table_linear_probe_core.sv
test/tb_top.sv
